// ===== sv/mms_pkg.sv =====
// Shared types, constants and helpers for the MIDI message splitter.
package mms_pkg;

    localparam logic [7:0] SYSEX_START       = 8'hF0;
    localparam logic [5:0] SYSEX_LIMIT_RESET = 6'd41;
    localparam int         MAX_RESULTS       = 3;

    localparam logic [3:0] STAT_NOTE_OFF   = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON    = 4'h9;
    localparam logic [3:0] STAT_POLY_PRESS = 4'hA;
    localparam logic [3:0] STAT_CTRL_CHG   = 4'hB;
    localparam logic [3:0] STAT_PROG_CHG   = 4'hC;
    localparam logic [3:0] STAT_CHAN_PRESS = 4'hD;
    localparam logic [3:0] STAT_PITCH_BEND = 4'hE;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_SYSEX   = 2'd2,
        MODE_DISCARD = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       packet_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       message_end;
    } out_item_t;

    typedef struct packed {
        logic [1:0]                  count;
        out_item_t [MAX_RESULTS-1:0] items;
    } parse_result_t;

    // message length in bytes for a status byte, 0 when not a channel status
    function automatic logic [1:0] msg_len(input logic [7:0] status);
        logic [1:0] len;
        len = 2'd0;
        case (status[7:4]) inside
            STAT_NOTE_OFF, STAT_NOTE_ON, STAT_POLY_PRESS,
            STAT_CTRL_CHG, STAT_PITCH_BEND: len = 2'd3;
            STAT_PROG_CHG, STAT_CHAN_PRESS: len = 2'd2;
            default:                        len = 2'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/mms_parser.sv =====
// Message framing state machine: turns one packet byte into up to three result bytes.
module mms_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [5:0]             sysex_limit,
    input  logic                   consume,
    input  mms_pkg::in_item_t      in_item,
    output mms_pkg::parse_result_t result
);
    import mms_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] data_reg, data_next;
    logic [1:0] need_reg, need_next;
    logic [5:0] sent_reg, sent_next;

    logic [7:0] b;
    logic       pend;
    logic [1:0] len_in;
    logic [5:0] eff_limit;
    logic [5:0] sent_inc;
    logic       sx_first_last;
    logic       sx_cont_last;

    assign b             = in_item.in_byte;
    assign pend          = in_item.packet_end;
    assign len_in        = msg_len(b);
    assign eff_limit     = (sysex_limit == 6'd0) ? 6'd1 : sysex_limit;
    assign sent_inc      = sent_reg + 6'd1;
    assign sx_first_last = pend || (eff_limit == 6'd1);
    assign sx_cont_last  = pend || (sent_inc >= eff_limit);

    // next state
    always_comb begin
        mode_next   = mode_reg;
        status_next = status_reg;
        data_next   = data_reg;
        need_next   = need_reg;
        sent_next   = sent_reg;
        unique case (mode_reg)
            MODE_IDLE: begin
                if (b == SYSEX_START) begin
                    sent_next = 6'd1;
                    mode_next = pend ? MODE_IDLE
                              : (sx_first_last ? MODE_DISCARD : MODE_SYSEX);
                end else if (len_in != 2'd0 && !pend) begin
                    status_next = b;
                    need_next   = len_in - 2'd1;
                    mode_next   = MODE_COLLECT;
                end
            end
            MODE_COLLECT: begin
                if (need_reg != 2'd1) begin
                    if (pend) begin
                        mode_next = MODE_IDLE;
                        need_next = 2'd0;
                    end else begin
                        data_next = b;
                        need_next = 2'd1;
                    end
                end else begin
                    mode_next = MODE_IDLE;
                    need_next = 2'd0;
                end
            end
            MODE_SYSEX: begin
                sent_next = sent_inc;
                mode_next = pend ? MODE_IDLE
                          : (sx_cont_last ? MODE_DISCARD : MODE_SYSEX);
            end
            MODE_DISCARD: begin
                if (pend) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    // result bytes
    always_comb begin
        result       = '0;
        unique case (mode_reg)
            MODE_IDLE: begin
                if (b == SYSEX_START) begin
                    result.count    = 2'd1;
                    result.items[0] = '{out_byte: b, message_end: sx_first_last};
                end
            end
            MODE_COLLECT: begin
                if (need_reg != 2'd1) begin
                    if (pend && b == SYSEX_START) begin
                        result.count    = 2'd1;
                        result.items[0] = '{out_byte: b, message_end: 1'b1};
                    end
                end else begin
                    result.items[0] = '{out_byte: status_reg, message_end: 1'b0};
                    if (msg_len(status_reg) == 2'd3) begin
                        result.count    = 2'd3;
                        result.items[1] = '{out_byte: data_reg, message_end: 1'b0};
                        result.items[2] = '{out_byte: b, message_end: 1'b1};
                    end else begin
                        result.count    = 2'd2;
                        result.items[1] = '{out_byte: b, message_end: 1'b1};
                    end
                end
            end
            MODE_SYSEX: begin
                result.count    = 2'd1;
                result.items[0] = '{out_byte: b, message_end: sx_cont_last};
            end
            MODE_DISCARD: result.count = 2'd0;
            default:      result.count = 2'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            status_reg <= '0;
            data_reg   <= '0;
            need_reg   <= '0;
            sent_reg   <= '0;
        end else if (consume) begin
            mode_reg   <= mode_next;
            status_reg <= status_next;
            data_reg   <= data_next;
            need_reg   <= need_next;
            sent_reg   <= sent_next;
        end
    end

endmodule

// ===== sv/mms_out_buf.sv =====
// Result buffer: holds up to three result bytes and hands them out one per transaction.
module mms_out_buf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  mms_pkg::parse_result_t result,
    output logic                   free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output mms_pkg::out_item_t     m_data
);
    import mms_pkg::*;

    out_item_t [MAX_RESULTS-1:0] items_reg, items_next;
    logic [1:0]                  rem_reg, rem_next;
    logic                        pop;

    assign m_valid = (rem_reg != 2'd0);
    assign m_data  = items_reg[0];
    assign pop     = m_valid && m_ready;
    assign free    = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_ready);

    always_comb begin
        items_next = items_reg;
        rem_next   = rem_reg;
        if (load) begin
            items_next = result.items;
            rem_next   = result.count;
        end else if (pop) begin
            items_next[0] = items_reg[1];
            items_next[1] = items_reg[2];
            rem_next      = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
        items_reg <= items_next;
    end

endmodule

// ===== sv/midi_message_splitter.sv =====
// Top level of the MIDI message splitter: input register, framing logic, result buffer.
//
//  channel | ports                      | payload
//  --------+----------------------------+-------------------------------
//  input   | s_valid s_ready s_data     | in_byte, packet_end
//  result  | m_valid m_ready m_data     | out_byte, message_end
//  config  | cfg_valid cfg_ready cfg_data | sysex_limit (6 bits)
//
// A byte is parsed from the input register once the result buffer is free; one byte
// per cycle is taken while each yields at most one result and m_ready is high. A
// completed channel message puts two or three bytes in the result buffer, one transaction each.
// Synchronous active-low reset: parser idle, buffer empty, sysex_limit = 41.
// Stalls on m_ready back up through the result buffer and input register to s_ready.
module midi_message_splitter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mms_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mms_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [5:0]         cfg_data
);
    import mms_pkg::*;

    in_item_t      in_reg;
    logic          in_valid_reg;
    logic [5:0]    limit_reg;
    logic          free;
    logic          consume;
    parse_result_t result;

    assign cfg_ready = 1'b1;
    assign consume   = in_valid_reg && free;
    assign s_ready   = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            limit_reg    <= SYSEX_LIMIT_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    mms_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sysex_limit (limit_reg),
        .consume     (consume),
        .in_item     (in_reg),
        .result      (result)
    );

    mms_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (consume),
        .result  (result),
        .free    (free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTH
    // a waiting input byte is held until the parser takes it
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !consume |=> in_valid_reg && $stable(in_reg))
        else $error("input register lost or changed a pending byte");

    // an accepted transaction always lands in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg && (in_reg == $past(s_data)))
        else $error("accepted input transaction not registered");

    // a config write takes effect on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> limit_reg == $past(cfg_data))
        else $error("sysex limit write not applied");

    // the parser only advances when the result buffer has room; its results then reach the buffer output
    assert property (@(posedge aclk) disable iff (!aresetn)
        consume && result.count != 2'd0 |=> m_valid)
        else $error("parsed results missing from result buffer");
`endif

endmodule

// ===== tb/tb_midi_message_splitter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for midi_message_splitter: packet traffic, framing prediction, result checks.
module tb_midi_message_splitter;
    import mms_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [5:0] cfg_data  = '0;

    // framing prediction state
    mode_t      parse_state;
    logic [7:0] held_status;
    logic [7:0] held_data;
    logic [1:0] data_needed;
    logic [5:0] sysex_count;
    logic [5:0] sysex_limit_reg;

    out_item_t  expected_bytes[$];
    logic [7:0] pkt_bytes[$];
    int         mismatch_count = 0;
    bit         gaps_on        = 1'b1;
    bit         stalls_on      = 1'b1;
    int         hold_left      = 0;
    int         stall_left     = 0;

    always #1 aclk = ~aclk;

    midi_message_splitter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic int status_len(input logic [7:0] status);
        case (status[7:4])
            STAT_NOTE_OFF, STAT_NOTE_ON, STAT_POLY_PRESS,
            STAT_CTRL_CHG, STAT_PITCH_BEND: return 3;
            STAT_PROG_CHG, STAT_CHAN_PRESS: return 2;
            default: return 0;
        endcase
    endfunction

    function automatic int sysex_cap();
        return (sysex_limit_reg == 6'd0) ? 1 : int'(sysex_limit_reg);
    endfunction

    function automatic void push_expect(input logic [7:0] b, input logic ends);
        out_item_t r;
        r.out_byte    = b;
        r.message_end = ends;
        expected_bytes.push_back(r);
    endfunction

    function automatic void frame_byte(input in_item_t it);
        logic [7:0] b;
        logic       pend;
        logic       ends;
        int         len;
        b    = it.in_byte;
        pend = it.packet_end;
        case (parse_state)
            MODE_IDLE: begin
                if (b == SYSEX_START) begin
                    sysex_count = 6'd1;
                    ends = pend || (int'(sysex_count) >= sysex_cap());
                    push_expect(b, ends);
                    parse_state = pend ? MODE_IDLE : (ends ? MODE_DISCARD : MODE_SYSEX);
                end else begin
                    len = status_len(b);
                    if (len != 0 && !pend) begin
                        held_status = b;
                        data_needed = 2'(len - 1);
                        parse_state = MODE_COLLECT;
                    end
                end
            end
            MODE_COLLECT: begin
                if (data_needed != 2'd1) begin
                    if (pend) begin
                        // cut short; a trailing 0xF0 leaves as a lone sysex
                        parse_state = MODE_IDLE;
                        data_needed = 2'd0;
                        if (b == SYSEX_START)
                            push_expect(b, 1'b1);
                    end else begin
                        held_data   = b;
                        data_needed = 2'd1;
                    end
                end else begin
                    parse_state = MODE_IDLE;
                    data_needed = 2'd0;
                    push_expect(held_status, 1'b0);
                    if (status_len(held_status) == 3)
                        push_expect(held_data, 1'b0);
                    push_expect(b, 1'b1);
                end
            end
            MODE_SYSEX: begin
                sysex_count = sysex_count + 6'd1;
                ends = pend || (int'(sysex_count) >= sysex_cap());
                push_expect(b, ends);
                parse_state = pend ? MODE_IDLE : (ends ? MODE_DISCARD : MODE_SYSEX);
            end
            default: begin
                if (pend)
                    parse_state = MODE_IDLE;
            end
        endcase
    endfunction

    function automatic logic [7:0] rand_data_byte();
        return ($urandom_range(0, 5) == 0) ? SYSEX_START : 8'($urandom_range(0, 255));
    endfunction

    // result ready: a long hold-off when one is requested, else random stall bursts
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (stalls_on && $urandom_range(0, 11) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 17);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected transaction: byte %h end %b", m_data.out_byte,
                             m_data.message_end);
            end else begin
                want = expected_bytes.pop_front();
                if (m_data.out_byte !== want.out_byte ||
                    m_data.message_end !== want.message_end) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: expected byte %h end %b, got byte %h end %b",
                                 want.out_byte, want.message_end,
                                 m_data.out_byte, m_data.message_end);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic pend);
        int gap;
        gap = (gaps_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_data.in_byte    <= b;
        s_data.packet_end <= pend;
        do @(posedge aclk); while (!s_ready);
        frame_byte(s_data);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        pkt_bytes.delete();
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [5:0] value);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sysex_limit_reg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic gen_packet();
        int         n_msgs;
        int         kind;
        int         i;
        int         k;
        int         len;
        logic [7:0] status;
        n_msgs = $urandom_range(1, 3);
        for (i = 0; i < n_msgs; i++) begin
            kind   = $urandom_range(0, 9);
            status = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
            if (kind <= 4) begin
                pkt_bytes.push_back(status);
                for (k = 1; k < status_len(status); k++)
                    pkt_bytes.push_back(rand_data_byte());
            end else if (kind <= 6) begin
                pkt_bytes.push_back(SYSEX_START);
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sysex_cap() + 2)
                                                  : $urandom_range(0, 4);
                for (k = 0; k < len; k++)
                    pkt_bytes.push_back(8'($urandom_range(0, 255)));
                break;
            end else if (kind == 7) begin
                // truncated channel message
                pkt_bytes.push_back(status);
                len = $urandom_range(0, status_len(status) - 2);
                for (k = 0; k < len; k++)
                    pkt_bytes.push_back(rand_data_byte());
                break;
            end else begin
                len = $urandom_range(1, 2);
                for (k = 0; k < len; k++)
                    pkt_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_channel_messages();
        pkt_bytes = '{8'h80, 8'h00, 8'h7F, 8'hC0, 8'hFF};
        send_packet();
        pkt_bytes = '{8'h9F, 8'hF0, 8'h80, 8'hD7, 8'h00};
        send_packet();
    endtask

    task automatic test_cut_short();
        pkt_bytes = '{8'hE3, 8'hF0};
        send_packet();
        pkt_bytes = '{8'hB0, 8'h12};
        send_packet();
        pkt_bytes = '{8'hA5};
        send_packet();
    endtask

    task automatic test_sysex();
        pkt_bytes = '{SYSEX_START};
        send_packet();
        pkt_bytes = '{SYSEX_START, 8'h01, 8'h02};
        send_packet();
        // data and system bytes at a message start are skipped
        pkt_bytes = '{8'h45, 8'hF8, 8'hF7};
        send_packet();
    endtask

    task automatic test_sysex_limit();
        write_limit(6'd2);
        pkt_bytes = '{SYSEX_START, 8'h11, 8'h22, 8'h33};
        send_packet();
    endtask

    task automatic test_backpressure();
        int i;
        settle();
        hold_left = 80;
        for (i = 0; i < 8; i++) begin
            pkt_bytes = '{{STAT_NOTE_ON, 4'(i)}, 8'(i * 16), 8'(255 - i)};
            send_packet();
        end
        settle();
    endtask

    task automatic test_random_traffic(input logic [5:0] limit_value, input int n_items);
        int count;
        write_limit(limit_value);
        count = 0;
        while (count < n_items) begin
            gen_packet();
            count += pkt_bytes.size();
            send_packet();
        end
    endtask

    initial begin
        parse_state     = MODE_IDLE;
        held_status     = '0;
        held_data       = '0;
        data_needed     = '0;
        sysex_count     = '0;
        sysex_limit_reg = SYSEX_LIMIT_RESET;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        test_channel_messages();
        test_cut_short();
        test_sysex();
        test_sysex_limit();
        test_backpressure();
        test_random_traffic(SYSEX_LIMIT_RESET, 6);
        test_random_traffic(6'd1, 6);
        test_random_traffic(6'd63, 6);
        test_random_traffic(6'd0, 6);
        test_random_traffic(6'($urandom_range(1, 62)), 6);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_random_traffic(SYSEX_LIMIT_RESET, 10);
        settle();

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== midi_message_splitter.f =====
sv/mms_pkg.sv
sv/mms_parser.sv
sv/mms_out_buf.sv
sv/midi_message_splitter.sv
tb/tb_midi_message_splitter.sv
